>>> hdl/scsu_pkg.sv
// Shared types and constants for the shadow call stack unwinder.
package scsu_pkg;

    localparam int STACK_DEPTH_DEF = 64;

    localparam int ID_W     = 32;
    localparam int ADDR_W   = 64;
    localparam int SIG_W    = 64;
    localparam int DEPTH_W  = 7;
    localparam int STATUS_W = 2;

    // input word: inst_id, address; output word: depth_after, signature, pad
    localparam int S_DATA_W = 96;
    localparam int M_DATA_W = 72;

    localparam logic OP_CALL = 1'b0;
    localparam logic OP_RET  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_MISS  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_DONE
    } state_t;

endpackage

>>> hdl/shadow_call_stack_unwinder_core.sv
// Shadow call stack unwinder: stack memories, scan sequencer and output register.
//
// A call, or a return on an empty stack, goes from accept through S_DONE to the output register.
// A return that scans k entries (1..depth) visits S_READ and then S_CMP for each entry, then S_DONE;
// each entry uses the single registered read port and then the shared adder.
// Throughput: one word at a time; s_tready is high again the cycle the result is registered.
// Reset (aresetn low, synchronous) empties the stack and clears the signature; the stack
// memories are not cleared, since only entries below the depth are ever read.
module shadow_call_stack_unwinder_core
    import scsu_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // [31:0] inst_id, [95:32] address
    input  logic                s_tuser,   // [0] op (0 call, 1 return)

    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // [6:0] depth_after, [70:7] signature, [71] zero
    output logic [STATUS_W-1:0] m_tuser    // [1:0] status
);

    localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(STACK_DEPTH);

    // stack storage, one read port with registered data
    logic [ID_W-1:0]   id_mem  [STACK_DEPTH];
    logic [ADDR_W-1:0] ret_mem [STACK_DEPTH];
    logic [ID_W-1:0]   rd_id_reg;
    logic [ADDR_W-1:0] rd_ret_reg;

    // architectural state
    logic [CNT_W-1:0]  depth_reg, depth_next;
    logic [SIG_W-1:0]  sig_reg,   sig_next;

    // scan state
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  pos_reg,   pos_next;
    logic [SIG_W-1:0]  work_reg,  work_next;
    logic [ADDR_W-1:0] target_reg, target_next;
    status_t           res_reg,   res_next;

    // output register
    logic                m_valid_reg, m_valid_next;
    status_t             m_status_reg, m_status_next;
    logic [DEPTH_W-1:0]  m_depth_reg, m_depth_next;
    logic [SIG_W-1:0]    m_sig_reg,   m_sig_next;

    // input word fields
    logic [ID_W-1:0]   in_id;
    logic [ADDR_W-1:0] in_addr;
    logic              s_fire;

    // memory control
    logic              push_en;
    logic              rd_en;
    logic [CNT_W-1:0]  pos_dec;
    logic [IDX_W-1:0]  rd_idx;
    logic [IDX_W-1:0]  wr_idx;

    // shared adder/subtractor
    logic [SIG_W-1:0]  alu_a, alu_b, alu_res;
    logic              alu_sub;

    assign in_id   = s_tdata[ID_W-1:0];
    assign in_addr = s_tdata[ID_W +: ADDR_W];
    assign s_tready = (state_reg == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;

    assign pos_dec = pos_reg - 1'b1;
    assign rd_idx  = pos_dec[IDX_W-1:0];
    assign wr_idx  = depth_reg[IDX_W-1:0];

    assign alu_res = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {1'b0, m_sig_reg, m_depth_reg};

    // sequencer and datapath next state
    always_comb begin
        state_next    = state_reg;
        depth_next    = depth_reg;
        sig_next      = sig_reg;
        pos_next      = pos_reg;
        work_next     = work_reg;
        target_next   = target_reg;
        res_next      = res_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_status_next = m_status_reg;
        m_depth_next  = m_depth_reg;
        m_sig_next    = m_sig_reg;
        push_en       = 1'b0;
        rd_en         = 1'b0;
        alu_a         = sig_reg;
        alu_b         = {{(SIG_W-ID_W){1'b0}}, in_id};
        alu_sub       = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    state_next = S_DONE;
                    if (s_tuser == OP_CALL) begin
                        if (depth_reg == FULL_CNT) begin
                            res_next = ST_FULL;
                        end else begin
                            push_en    = 1'b1;
                            depth_next = depth_reg + 1'b1;
                            sig_next   = alu_res;
                            res_next   = ST_OK;
                        end
                    end else if (depth_reg == '0) begin
                        res_next = ST_EMPTY;
                    end else begin
                        pos_next    = depth_reg;
                        work_next   = sig_reg;
                        target_next = in_addr;
                        state_next  = S_READ;
                    end
                end
            end
            S_READ: begin
                rd_en      = 1'b1;
                pos_next   = pos_dec;
                state_next = S_CMP;
            end
            S_CMP: begin
                // peel one entry off the running sum
                alu_a     = work_reg;
                alu_b     = {{(SIG_W-ID_W){1'b0}}, rd_id_reg};
                alu_sub   = 1'b1;
                work_next = alu_res;
                if (rd_ret_reg == target_reg) begin
                    depth_next = pos_reg;
                    sig_next   = alu_res;
                    res_next   = ST_OK;
                    state_next = S_DONE;
                end else if (pos_reg == '0) begin
                    res_next   = ST_MISS;
                    state_next = S_DONE;
                end else begin
                    state_next = S_READ;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_reg;
                    m_depth_next  = DEPTH_W'(depth_reg);
                    m_sig_next    = sig_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            depth_reg   <= '0;
            sig_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            depth_reg   <= depth_next;
            sig_reg     <= sig_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg      <= pos_next;
        work_reg     <= work_next;
        target_reg   <= target_next;
        res_reg      <= res_next;
        m_status_reg <= m_status_next;
        m_depth_reg  <= m_depth_next;
        m_sig_reg    <= m_sig_next;
    end

    always_ff @(posedge aclk) begin
        if (push_en) begin
            id_mem[wr_idx]  <= in_id;
            ret_mem[wr_idx] <= in_addr;
        end
        if (rd_en) begin
            rd_id_reg  <= id_mem[rd_idx];
            rd_ret_reg <= ret_mem[rd_idx];
        end
    end

    // depth never passes capacity
    a_depth_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= FULL_CNT)
        else $error("stack depth above capacity");

    // the scan pointer stays below the top of stack while comparing
    a_scan_below_top: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CMP) |-> (pos_reg < depth_reg))
        else $error("scan pointer at or above top of stack");

    // a dropped call is reported only when the stack is full
    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && res_reg == ST_FULL) |-> (depth_reg == FULL_CNT))
        else $error("full status with room left");

    // an empty-stack return is reported only when the stack is empty
    a_empty_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && res_reg == ST_EMPTY) |-> (depth_reg == '0))
        else $error("empty status with entries stacked");

    // a miss leaves depth and signature untouched
    a_miss_keeps_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CMP && state_next == S_DONE && rd_ret_reg != target_reg)
            |=> ($stable(depth_reg) && $stable(sig_reg)))
        else $error("state changed on return miss");

endmodule
